/* rtl/irfc_pkg.sv */
package irfc_pkg;

  // configuration port widths
  localparam int CFG_INDEX_BITS = 3;
  localparam int CFG_DATA_BITS  = 9;

  // size register reset value
  localparam logic [CFG_DATA_BITS-1:0] SIZE_RESET = 9'd256;

  // input command codes
  localparam logic CMD_LOAD  = 1'b0;
  localparam logic CMD_FETCH = 1'b1;

  // output mapping modes; codes above resize act as resize
  typedef enum logic [2:0] {
    MODE_ROT_CCW   = 3'd0,
    MODE_ROT_CW    = 3'd1,
    MODE_MIRROR_LR = 3'd2,
    MODE_MIRROR_TB = 3'd3,
    MODE_RESIZE    = 3'd4
  } mode_t;

  // configuration register indexes
  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_MODE          = 3'd0,
    REG_SOURCE_WIDTH  = 3'd1,
    REG_SOURCE_HEIGHT = 3'd2,
    REG_TARGET_WIDTH  = 3'd3,
    REG_TARGET_HEIGHT = 3'd4
  } cfg_reg_t;

endpackage

/* rtl/irfc_if.sv */
// pixel input channel: load or fetch command with pixel channels
interface irfc_pixel_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic                    command;
  logic [CHANNEL_BITS-1:0] red;
  logic [CHANNEL_BITS-1:0] green;
  logic [CHANNEL_BITS-1:0] blue;

  modport source (output valid, command, red, green, blue, input ready);
  modport sink (input valid, command, red, green, blue, output ready);
endinterface

// result channel: one fetched pixel per beat
interface irfc_result_if #(parameter int CHANNEL_BITS = 8);
  logic                    valid;
  logic                    ready;
  logic [CHANNEL_BITS-1:0] out_red;
  logic [CHANNEL_BITS-1:0] out_green;
  logic [CHANNEL_BITS-1:0] out_blue;
  logic                    last_pixel;

  modport source (output valid, out_red, out_green, out_blue, last_pixel, input ready);
  modport sink (input valid, out_red, out_green, out_blue, last_pixel, output ready);
endinterface

// configuration write channel
interface irfc_cfg_if;
  logic                                valid;
  logic                                ready;
  logic [irfc_pkg::CFG_INDEX_BITS-1:0] index;
  logic [irfc_pkg::CFG_DATA_BITS-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* rtl/image_rotate_flip_crop_core.sv */
// channel  | dir | beat contents
// ---------+-----+--------------------------------------------------
// pixel    | in  | command (load/fetch), red, green, blue
// result   | out | out_red, out_green, out_blue, last_pixel
// cfg      | in  | index, data (mode and size registers)
//
// a load writes the frame store in the cycle it is accepted; a fetch forms its
// store address in that cycle (one multiplier) and holds it in the address
// stage; the store is read as the fetch leaves that stage into the output register.
// sustained rate is one item per cycle while result beats are taken.
// pixel.ready drops while a fetch holds the address stage and the output
// register is stalled. reset clears counters, valid flags and configuration
// registers; the frame store is not cleared. cfg is always ready.
module image_rotate_flip_crop_core #(
  parameter int MAX_WIDTH    = 256,
  parameter int MAX_HEIGHT   = 256,
  parameter int CHANNEL_BITS = 8
) (
  input  logic                 clk,
  input  logic                 rst,
  irfc_pixel_if.sink           pixel,
  irfc_result_if.source        result,
  irfc_cfg_if.sink             cfg
);

  localparam int DIM   = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
  localparam int CW    = $clog2(DIM);
  localparam int SW    = $clog2(DIM + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int TW    = $clog2(DEPTH + 1);
  localparam int PW    = 3 * CHANNEL_BITS;
  localparam int DB    = irfc_pkg::CFG_DATA_BITS;

  // configuration registers
  logic [2:0]    mode;
  logic [DB-1:0] src_w;
  logic [DB-1:0] src_h;
  logic [DB-1:0] tgt_w;
  logic [DB-1:0] tgt_h;

  // counters
  logic [AW-1:0] load_pos;
  logic [AW-1:0] load_pos_next;
  logic [CW-1:0] out_row;
  logic [CW-1:0] out_col;
  logic [CW-1:0] out_row_next;
  logic [CW-1:0] out_col_next;

  // address stage and output register
  logic          s1_valid;
  logic [AW-1:0] s1_addr;
  logic          s1_black;
  logic          s1_last;
  logic          s1_go;
  logic          out_valid;
  logic          out_black;
  logic          out_last;
  logic [PW-1:0] rd_pix;

  logic [PW-1:0] store [DEPTH];

  logic          in_go;
  logic          load_go;
  logic          fetch_go;

  // clamped sizes
  logic [SW-1:0] w;
  logic [SW-1:0] h;
  logic [SW-1:0] tw;
  logic [SW-1:0] th;
  logic [SW-1:0] ow;
  logic [SW-1:0] oh;

  logic [TW-1:0] total;
  logic [AW-1:0] ld_addr;
  logic [TW-1:0] ld_inc;

  logic          wrap;
  logic [CW-1:0] r;
  logic [CW-1:0] c;
  logic [CW-1:0] sr;
  logic [CW-1:0] sc;
  logic          blk;
  logic          last;
  logic [AW-1:0] addr;
  logic [SW-1:0] c_inc;
  logic [SW-1:0] r_inc;

  // handshakes
  assign s1_go    = s1_valid && (!out_valid || result.ready);
  assign pixel.ready = !s1_valid || s1_go;
  assign in_go    = pixel.valid && pixel.ready;
  assign load_go  = in_go && (pixel.command == irfc_pkg::CMD_LOAD);
  assign fetch_go = in_go && (pixel.command == irfc_pkg::CMD_FETCH);
  assign cfg.ready = 1'b1;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      mode  <= irfc_pkg::MODE_ROT_CCW;
      src_w <= irfc_pkg::SIZE_RESET;
      src_h <= irfc_pkg::SIZE_RESET;
      tgt_w <= irfc_pkg::SIZE_RESET;
      tgt_h <= irfc_pkg::SIZE_RESET;
    end else if (cfg.valid) begin
      unique case (irfc_pkg::cfg_reg_t'(cfg.index))
        irfc_pkg::REG_MODE:          mode  <= cfg.data[2:0];
        irfc_pkg::REG_SOURCE_WIDTH:  src_w <= cfg.data;
        irfc_pkg::REG_SOURCE_HEIGHT: src_h <= cfg.data;
        irfc_pkg::REG_TARGET_WIDTH:  tgt_w <= cfg.data;
        irfc_pkg::REG_TARGET_HEIGHT: tgt_h <= cfg.data;
        default: ;
      endcase
    end
  end

  // saturate sizes to 1..max
  always_comb begin
    if (src_w == '0) w = SW'(1);
    else if (32'(src_w) > 32'(MAX_WIDTH)) w = SW'(MAX_WIDTH);
    else w = SW'(src_w);
    if (src_h == '0) h = SW'(1);
    else if (32'(src_h) > 32'(MAX_HEIGHT)) h = SW'(MAX_HEIGHT);
    else h = SW'(src_h);
    if (tgt_w == '0) tw = SW'(1);
    else if (32'(tgt_w) > 32'(MAX_WIDTH)) tw = SW'(MAX_WIDTH);
    else tw = SW'(tgt_w);
    if (tgt_h == '0) th = SW'(1);
    else if (32'(tgt_h) > 32'(MAX_HEIGHT)) th = SW'(MAX_HEIGHT);
    else th = SW'(tgt_h);
  end

  // load address and wrap
  always_comb begin
    total   = TW'(w) * TW'(h);
    ld_addr = (TW'(load_pos) >= total) ? '0 : load_pos;
    ld_inc  = TW'(ld_addr) + TW'(1);
    load_pos_next = (ld_inc >= total) ? '0 : AW'(ld_inc);
  end

  // output frame size
  always_comb begin
    case (irfc_pkg::mode_t'(mode)) inside
      irfc_pkg::MODE_ROT_CCW, irfc_pkg::MODE_ROT_CW: begin
        ow = h;
        oh = w;
      end
      irfc_pkg::MODE_MIRROR_LR, irfc_pkg::MODE_MIRROR_TB: begin
        ow = w;
        oh = h;
      end
      default: begin
        ow = tw;
        oh = th;
      end
    endcase
  end

  // source position for the current output pixel
  always_comb begin
    wrap = (SW'(out_row) >= oh) || (SW'(out_col) >= ow);
    r    = wrap ? '0 : out_row;
    c    = wrap ? '0 : out_col;
    blk  = 1'b0;
    case (irfc_pkg::mode_t'(mode))
      irfc_pkg::MODE_ROT_CCW: begin
        sr = c;
        sc = CW'(w - SW'(1) - SW'(r));
      end
      irfc_pkg::MODE_ROT_CW: begin
        sr = CW'(h - SW'(1) - SW'(c));
        sc = r;
      end
      irfc_pkg::MODE_MIRROR_LR: begin
        sr = r;
        sc = CW'(w - SW'(1) - SW'(c));
      end
      irfc_pkg::MODE_MIRROR_TB: begin
        sr = CW'(h - SW'(1) - SW'(r));
        sc = c;
      end
      default: begin
        sr  = r;
        sc  = c;
        blk = (SW'(r) >= h) || (SW'(c) >= w);
      end
    endcase
    addr = AW'(sr) * AW'(w) + AW'(sc);
    last = (SW'(r) == oh - SW'(1)) && (SW'(c) == ow - SW'(1));
  end

  // advance output counters in raster order
  always_comb begin
    c_inc = SW'(c) + SW'(1);
    r_inc = SW'(r) + SW'(1);
    if (c_inc >= ow) begin
      out_col_next = '0;
      out_row_next = (r_inc >= oh) ? '0 : CW'(r_inc);
    end else begin
      out_col_next = CW'(c_inc);
      out_row_next = r;
    end
  end

  // counter registers
  always_ff @(posedge clk) begin
    if (rst) begin
      load_pos <= '0;
      out_row  <= '0;
      out_col  <= '0;
    end else begin
      if (load_go) load_pos <= load_pos_next;
      if (fetch_go) begin
        out_row <= out_row_next;
        out_col <= out_col_next;
      end
    end
  end

  // address stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (fetch_go) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fetch_go) begin
      s1_addr  <= addr;
      s1_black <= blk;
      s1_last  <= last;
    end
  end

  // frame store: write on load, registered read as a fetch leaves the address stage
  always_ff @(posedge clk) begin
    if (load_go) store[ld_addr] <= {pixel.red, pixel.green, pixel.blue};
    if (s1_go) rd_pix <= store[s1_addr];
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_go) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_black <= s1_black;
      out_last  <= s1_last;
    end
  end

  assign result.valid      = out_valid;
  assign result.out_red    = out_black ? '0 : rd_pix[PW-1 -: CHANNEL_BITS];
  assign result.out_green  = out_black ? '0 : rd_pix[2*CHANNEL_BITS-1 -: CHANNEL_BITS];
  assign result.out_blue   = out_black ? '0 : rd_pix[CHANNEL_BITS-1:0];
  assign result.last_pixel = out_last;

  // a fetch always lands in the address stage
  a_fetch_enters: assert property (@(posedge clk) disable iff (rst)
    fetch_go |=> s1_valid)
    else $error("fetch beat lost before address stage");

  // a fetch leaving the address stage always reaches the output register
  a_stage_to_out: assert property (@(posedge clk) disable iff (rst)
    s1_go |=> out_valid)
    else $error("fetch beat lost before output register");

  // a held fetch keeps its store address
  a_addr_held: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |=> (s1_valid && $stable(s1_addr)))
    else $error("address stage changed while stalled");

  // nothing enters while the address stage is blocked
  a_no_accept_blocked: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_go) |-> !in_go)
    else $error("input accepted while address stage blocked");

endmodule
